// ===== hdl/arre_pkg.sv =====
`default_nettype none

package arre_pkg;

	localparam int MAX_CHANNELS  = 8;
	localparam int MAX_STAGES    = 8;
	localparam int FRACTION_BITS = 8;

	localparam int UPD_OLD_WEIGHT = 119;
	localparam int UPD_NEW_WEIGHT = 9;
	localparam int UPD_SHIFT      = 7;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_COUNT      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THRESHOLD    = 2'd2;

	localparam logic [3:0] RST_STAGE_COUNT      = 4'd8;
	localparam logic [6:0] RST_ESCAPE_THRESHOLD = 7'd32;
	localparam logic [7:0] RST_LOW_THRESHOLD    = 8'd2;

	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ACALC,
		ST_FINIT,
		ST_FDIV,
		ST_FFIN,
		ST_EMIT1,
		ST_EMIT2,
		ST_EMIT3
	} state_t;

	function automatic logic [5:0] bit_len(input logic [33:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 34; i++) begin
			if (v[i]) n = 6'(i + 1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/adaptive_recursive_rice_encoder_core.sv =====
// Adaptive recursive Rice / Golomb encoder for interleaved residual channels.
// Input beats arrive on the s_ group: tuser is the kind (load or sample) and
// tdata carries channel, sample and initial parameter. A load beat fills the
// channel's stage means and divisor and fixes its mode; it gives no output.
// A sample beat gives one to three code chunks on the m_ group, tlast marking
// the final chunk of the codeword.
// Stage means live in a synchronous memory of channels times stages entries.
// An adaptive sample reads, updates and writes back one stage mean per cycle.
// A fixed-mode sample runs a one-bit-per-cycle restoring divider.
// A load sweeps every stage of its channel in the stage memory.
// Further chunks follow at one per cycle while the receiver is ready.
// One item is worked on at a time; the next beat is taken once the last chunk
// sits in the output register, so work overlaps a stalled receiver.
// When the receiver stalls, the output register holds its beat and the block
// waits with the next chunk. Reset clears the control state, the channel mode
// flags and the configuration registers; the memories are not cleared.
`default_nettype none

module adaptive_recursive_rice_encoder_core #(
	parameter int MAX_CHANNELS  = arre_pkg::MAX_CHANNELS,
	parameter int MAX_STAGES    = arre_pkg::MAX_STAGES,
	parameter int FRACTION_BITS = arre_pkg::FRACTION_BITS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [arre_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [arre_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// channel[2:0], sample[34:3], start_mean[66:35], zero fill above
	input  wire  [arre_pkg::IN_TDATA_W-1:0]      s_tdata,
	// kind
	input  wire                                  s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// zero_run[31:0], code_bits[64:32], bit_count[70:65], zero fill above
	output logic [arre_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);

	localparam int MW    = 32 + FRACTION_BITS;
	localparam int DEPTH = MAX_CHANNELS * MAX_STAGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SCW   = $clog2(MAX_STAGES + 1);
	localparam int UPDW_EXTRA = 8;
	localparam int PW    = MW + UPDW_EXTRA;

	arre_pkg::state_t state_q, state_d;

	logic [3:0] stage_count_q;
	logic [6:0] esc_thr_q;
	logic [7:0] low_thr_q;

	logic [MW-1:0] mean_mem_q [DEPTH];
	logic [31:0]   div_mem_q  [MAX_CHANNELS];
	logic [MW-1:0] mean_rd_q;
	logic [31:0]   div_rd_q;
	logic [MAX_CHANNELS-1:0] mode_q;

	logic [2:0]  in_ch;
	logic [31:0] in_sample, in_init, in_first, in_zz;
	logic        in_ch_ok, accept;

	logic [AW-1:0]  base_q, rd_addr, wr_addr;
	logic [SCW-1:0] i_q, n_q;
	logic [31:0]    v_q, init_q;
	logic           mean_we, push, slot_free;
	logic [MW-1:0]  mean_wd;

	logic [MW:0]     h_sum;
	logic [31:0]     h, hh, w;
	logic [4:0]      k;
	logic [PW-1:0]   upd_sum;
	logic [MW-1:0]   mean_new;
	logic            last_stage;
	logic [33:0]     tail_q;

	logic [31:0] m_q, quo_q;
	logic [32:0] rem_q, rem_n;
	logic [4:0]  step_q;

	logic        pow2;
	logic [5:0]  fb, nb;
	logic [32:0] ft, fval;

	logic [31:0] p1_zr_q;
	logic [32:0] p1_code_q;
	logic [5:0]  p1_cnt_q;
	logic        p1_last_q, escape_q;
	logic [33:0] g_q;
	logic [4:0]  k_q;
	logic [31:0] rest_q;
	logic [5:0]  g_len;

	logic        out_valid_q, out_last_q;
	logic [31:0] out_zr_q;
	logic [32:0] out_code_q;
	logic [5:0]  out_cnt_q;

	assign in_ch     = s_tdata[2:0];
	assign in_sample = s_tdata[34:3];
	assign in_init   = s_tdata[66:35];
	assign in_first  = (in_init == 32'd0) ? 32'd1 : in_init;
	assign in_zz     = {in_sample[30:0], 1'b0} ^ {32{in_sample[31]}};
	assign in_ch_ok  = 32'(in_ch) < MAX_CHANNELS;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= arre_pkg::RST_STAGE_COUNT;
			esc_thr_q     <= arre_pkg::RST_ESCAPE_THRESHOLD;
			low_thr_q     <= arre_pkg::RST_LOW_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				arre_pkg::CFG_STAGE_COUNT:      stage_count_q <= cfg_data[3:0];
				arre_pkg::CFG_ESCAPE_THRESHOLD: esc_thr_q     <= cfg_data[6:0];
				arre_pkg::CFG_LOW_THRESHOLD:    low_thr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rd_addr = (state_q == arre_pkg::ST_IDLE) ?
		AW'(32'(in_ch) * MAX_STAGES) : AW'(base_q + AW'(i_q) + AW'(1));
	assign wr_addr = AW'(base_q + AW'(i_q));
	assign mean_wd = (state_q == arre_pkg::ST_LOAD) ?
		(MW'(init_q) << FRACTION_BITS) : mean_new;

	always_ff @(posedge clk) begin
		if (mean_we) mean_mem_q[wr_addr] <= mean_wd;
		mean_rd_q <= mean_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch_ok && s_tuser == arre_pkg::KIND_LOAD) begin
			div_mem_q[CW'(in_ch)] <= in_first;
		end
		div_rd_q <= div_mem_q[CW'(in_ch)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (accept && in_ch_ok && s_tuser == arre_pkg::KIND_LOAD) begin
			mode_q[CW'(in_ch)] <= in_first > 32'(low_thr_q);
		end
	end

	assign h_sum = (MW+1)'(mean_rd_q >> 1) + ((MW+1)'(1) << (FRACTION_BITS - 1));
	assign h     = 32'(h_sum >> FRACTION_BITS);
	assign hh    = (h <= 32'd1) ? 32'd1 : h - 32'd1;
	assign k     = (h <= 32'd1) ? 5'd0 : 5'(arre_pkg::bit_len(34'(hh)));
	assign w     = 32'd1 << k;
	assign upd_sum = PW'(mean_rd_q) * PW'(arre_pkg::UPD_OLD_WEIGHT)
		+ ((PW'(v_q) << FRACTION_BITS) * PW'(arre_pkg::UPD_NEW_WEIGHT))
		+ (PW'(1) << (arre_pkg::UPD_SHIFT - 1));
	assign mean_new   = MW'(upd_sum >> arre_pkg::UPD_SHIFT);
	assign last_stage = (i_q == n_q - SCW'(1));
	assign tail_q     = 34'(i_q) + 34'(v_q >> k);

	assign rem_n = {rem_q[31:0], quo_q[31]};

	assign pow2 = (m_q & (m_q - 32'd1)) == 32'd0;
	assign fb   = arre_pkg::bit_len(34'(m_q));
	assign ft   = (33'd1 << fb) - 33'(m_q);
	always_comb begin
		if (pow2) begin
			nb   = fb - 6'd1;
			fval = 33'(rem_q[31:0]);
		end else if (33'(rem_q[31:0]) < ft) begin
			nb   = fb - 6'd1;
			fval = 33'(rem_q[31:0]);
		end else begin
			nb   = fb;
			fval = 33'(rem_q[31:0]) + ft;
		end
	end

	assign g_len     = arre_pkg::bit_len(g_q);
	assign slot_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= arre_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mean_we  = 1'b0;
		push     = 1'b0;
		case (state_q)
			arre_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_ch_ok) begin
					if (s_tuser == arre_pkg::KIND_LOAD) state_d = arre_pkg::ST_LOAD;
					else if (mode_q[CW'(in_ch)])      state_d = arre_pkg::ST_ACALC;
					else                              state_d = arre_pkg::ST_FINIT;
				end
			end
			arre_pkg::ST_LOAD: begin
				mean_we = 1'b1;
				if (i_q == SCW'(MAX_STAGES - 1)) state_d = arre_pkg::ST_IDLE;
			end
			arre_pkg::ST_ACALC: begin
				mean_we = 1'b1;
				if (last_stage || v_q < w) state_d = arre_pkg::ST_EMIT1;
			end
			arre_pkg::ST_FINIT: state_d = arre_pkg::ST_FDIV;
			arre_pkg::ST_FDIV: begin
				if (step_q == 5'd31) state_d = arre_pkg::ST_FFIN;
			end
			arre_pkg::ST_FFIN: state_d = arre_pkg::ST_EMIT1;
			arre_pkg::ST_EMIT1: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = escape_q ? arre_pkg::ST_EMIT2 : arre_pkg::ST_IDLE;
				end
			end
			arre_pkg::ST_EMIT2: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = (k_q != 5'd0) ? arre_pkg::ST_EMIT3 : arre_pkg::ST_IDLE;
				end
			end
			arre_pkg::ST_EMIT3: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = arre_pkg::ST_IDLE;
				end
			end
			default: state_d = arre_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			arre_pkg::ST_IDLE: begin
				base_q   <= AW'(32'(in_ch) * MAX_STAGES);
				i_q      <= '0;
				v_q      <= in_zz;
				init_q   <= in_init;
				escape_q <= 1'b0;
				if (stage_count_q == 4'd0)                   n_q <= SCW'(1);
				else if (32'(stage_count_q) > MAX_STAGES)    n_q <= SCW'(MAX_STAGES);
				else                                         n_q <= SCW'(stage_count_q);
			end
			arre_pkg::ST_LOAD: i_q <= i_q + SCW'(1);
			arre_pkg::ST_ACALC: begin
				k_q    <= k;
				rest_q <= v_q & (w - 32'd1);
				if (!last_stage) begin
					if (v_q < w) begin
						p1_zr_q   <= 32'(i_q);
						p1_code_q <= (33'd1 << k) | 33'(v_q & (w - 32'd1));
						p1_cnt_q  <= 6'(k) + 6'd1;
						p1_last_q <= 1'b1;
					end else begin
						v_q <= v_q - w;
						i_q <= i_q + SCW'(1);
					end
				end else if (tail_q < 34'(esc_thr_q)) begin
					p1_zr_q   <= tail_q[31:0];
					p1_code_q <= (33'd1 << k) | 33'(v_q & (w - 32'd1));
					p1_cnt_q  <= 6'(k) + 6'd1;
					p1_last_q <= 1'b1;
				end else begin
					p1_zr_q   <= 32'(esc_thr_q);
					p1_code_q <= 33'd1;
					p1_cnt_q  <= 6'd1;
					p1_last_q <= 1'b0;
					escape_q  <= 1'b1;
					g_q       <= tail_q - 34'(esc_thr_q) + 34'd1;
				end
			end
			arre_pkg::ST_FINIT: begin
				m_q    <= (div_rd_q == 32'd0) ? 32'd1 : div_rd_q;
				rem_q  <= '0;
				quo_q  <= v_q;
				step_q <= '0;
			end
			arre_pkg::ST_FDIV: begin
				step_q <= step_q + 5'd1;
				if (rem_n >= 33'(m_q)) begin
					rem_q <= rem_n - 33'(m_q);
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			arre_pkg::ST_FFIN: begin
				p1_zr_q   <= quo_q;
				p1_code_q <= (33'd1 << nb) | fval;
				p1_cnt_q  <= nb + 6'd1;
				p1_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (push)     out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			case (state_q)
				arre_pkg::ST_EMIT2: begin
					out_zr_q   <= 32'(g_len - 6'd1);
					out_code_q <= g_q[32:0];
					out_cnt_q  <= g_len;
					out_last_q <= (k_q == 5'd0);
				end
				arre_pkg::ST_EMIT3: begin
					out_zr_q   <= '0;
					out_code_q <= 33'(rest_q);
					out_cnt_q  <= 6'(k_q);
					out_last_q <= 1'b1;
				end
				default: begin
					out_zr_q   <= p1_zr_q;
					out_code_q <= p1_code_q;
					out_cnt_q  <= p1_cnt_q;
					out_last_q <= p1_last_q;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_code_q, out_zr_q};

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arre_pkg::ST_FDIV |-> rem_q < 33'(m_q))
		else $error("divider remainder out of range");

	a_mean_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mean_we |-> (state_q == arre_pkg::ST_LOAD || state_q == arre_pkg::ST_ACALC))
		else $error("stage mean written outside load or update");

	a_third_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arre_pkg::ST_EMIT3 |-> (k_q != 5'd0 && escape_q))
		else $error("remainder chunk without escape or width");

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("chunk pushed over a held beat");

endmodule

`default_nettype wire
